/* design/rbi_pkg.sv */
package rbi_pkg;

  localparam int WORD_BITS = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_STEPS = 9;
  localparam int STEP_W    = $clog2(MAX_STEPS);

  localparam logic [1:0] REQ_INTEGRATE = 2'd0;
  localparam logic [1:0] REQ_ADVANCE   = 2'd1;
  localparam logic [1:0] REQ_IMPULSE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_INERTIA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_DT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_DAMP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_DAMP    = 3'd6;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] torque;
    logic [30:0]        dt;
    logic signed [31:0] impulse_x;
    logic signed [31:0] impulse_y;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] ang_vel;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] rotation;
  } out_res_t;

  typedef enum logic [3:0] {
    A_FX, A_FY, A_TQ, A_IX, A_IY, A_CX, A_CY, A_VX, A_VY, A_W, A_T0, A_T1, A_T2
  } a_sel_t;

  typedef enum logic [2:0] {
    B_IM, B_II, B_FDT, B_LD, B_AD, B_DT, B_IX, B_IY
  } b_sel_t;

  typedef enum logic [3:0] {
    D_VX, D_VY, D_W, D_PX, D_PY, D_ANG, D_T0, D_T1, D_T2
  } dst_t;

  typedef enum logic [2:0] {
    S_ZERO, S_GX, S_GY, S_DST, S_T0
  } add_sel_t;

  // one multiply, then dst = sat(addend +/- sat(product))
  typedef struct packed {
    a_sel_t   a_sel;
    b_sel_t   b_sel;
    dst_t     dst;
    add_sel_t add_sel;
    logic     sub;
    logic     last;
  } uop_t;

  typedef struct packed {
    logic load_in;
    logic issue;
    uop_t uop;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic static_body;
  } dp_status_t;

  function automatic uop_t mk(a_sel_t a, b_sel_t b, dst_t d, add_sel_t s,
                              logic sub, logic last);
    uop_t u;
    u.a_sel   = a;
    u.b_sel   = b;
    u.dst     = d;
    u.add_sel = s;
    u.sub     = sub;
    u.last    = last;
    return u;
  endfunction

  // Step order places each read of a result after the write of that result has landed.
  function automatic uop_t ucode(logic [1:0] req, logic [STEP_W-1:0] step);
    uop_t u;
    u = mk(A_T0, B_IM, D_T0, S_ZERO, 1'b0, 1'b1);
    case (req)
      REQ_INTEGRATE: begin
        case (step)
          4'd0:    u = mk(A_FX, B_IM,  D_T0, S_GX,   1'b0, 1'b0);
          4'd1:    u = mk(A_TQ, B_II,  D_T2, S_ZERO, 1'b0, 1'b0);
          4'd2:    u = mk(A_FY, B_IM,  D_T1, S_GY,   1'b0, 1'b0);
          4'd3:    u = mk(A_T0, B_FDT, D_VX, S_DST,  1'b0, 1'b0);
          4'd4:    u = mk(A_T2, B_FDT, D_W,  S_DST,  1'b0, 1'b0);
          4'd5:    u = mk(A_T1, B_FDT, D_VY, S_DST,  1'b0, 1'b0);
          4'd6:    u = mk(A_VX, B_LD,  D_VX, S_ZERO, 1'b0, 1'b0);
          4'd7:    u = mk(A_W,  B_AD,  D_W,  S_ZERO, 1'b0, 1'b0);
          default: u = mk(A_VY, B_LD,  D_VY, S_ZERO, 1'b0, 1'b1);
        endcase
      end
      REQ_ADVANCE: begin
        case (step)
          4'd0:    u = mk(A_VX, B_DT, D_PX,  S_DST, 1'b0, 1'b0);
          4'd1:    u = mk(A_VY, B_DT, D_PY,  S_DST, 1'b0, 1'b0);
          default: u = mk(A_W,  B_DT, D_ANG, S_DST, 1'b0, 1'b1);
        endcase
      end
      REQ_IMPULSE: begin
        case (step)
          4'd0:    u = mk(A_CX, B_IY, D_T0, S_ZERO, 1'b0, 1'b0);
          4'd1:    u = mk(A_IX, B_IM, D_VX, S_DST,  1'b0, 1'b0);
          4'd2:    u = mk(A_CY, B_IX, D_T1, S_T0,   1'b1, 1'b0);
          4'd3:    u = mk(A_IY, B_IM, D_VY, S_DST,  1'b0, 1'b0);
          default: u = mk(A_T1, B_II, D_W,  S_DST,  1'b0, 1'b1);
        endcase
      end
      default: u = mk(A_T0, B_IM, D_T0, S_ZERO, 1'b0, 1'b1);
    endcase
    return u;
  endfunction

endpackage

/* design/rbi_ctrl.sv */
module rbi_ctrl
  import rbi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        req_r, req_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.uop       = ucode(req_r, step_r);
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          req_nxt     = in_req_type;
          step_nxt    = '0;
          // static body (integrate or advance) or unused code: no state change, just report
          if (in_req_type == REQ_IMPULSE ||
              (in_req_type inside {REQ_INTEGRATE, REQ_ADVANCE} && !status.static_body)) begin
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (cmd.uop.last) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      req_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_r       <= req_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/rbi_dp.sv */
module rbi_dp
  import rbi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  in_req_t              in_data,
  output out_res_t             out_data,
  input  dp_cmd_t              cmd,
  output dp_status_t           status
);

  localparam int W = WORD_BITS;

  logic [30:0]  inv_mass_r, inv_inertia_r, fixed_dt_r;
  logic [16:0]  lin_damp_r, ang_damp_r;
  logic signed [W-1:0] grav_x_r, grav_y_r;

  in_req_t  in_r;
  out_res_t out_r;

  logic signed [W-1:0] vx_r, vy_r, w_r, px_r, py_r, ang_r, t0_r, t1_r, t2_r;

  logic signed [W-1:0]     a_val, b_val;
  logic signed [2*W-1:0]   prod;
  logic signed [2*W-17:0]  prod_r;
  uop_t                    wb_uop_r;
  logic                    wb_vld_r;

  logic signed [W-1:0] p_sat, addend, dst_val, res;
  logic signed [W:0]   sum;

  assign status.static_body = (inv_mass_r == '0);
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r    <= 31'd65536;
      inv_inertia_r <= 31'd65536;
      grav_x_r      <= '0;
      grav_y_r      <= '0;
      fixed_dt_r    <= 31'd1092;
      lin_damp_r    <= 17'd65536;
      ang_damp_r    <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_MASS:    inv_mass_r    <= cfg_wdata[30:0];
        CFG_INV_INERTIA: inv_inertia_r <= cfg_wdata[30:0];
        CFG_GRAVITY_X:   grav_x_r      <= cfg_wdata;
        CFG_GRAVITY_Y:   grav_y_r      <= cfg_wdata;
        CFG_FIXED_DT:    fixed_dt_r    <= cfg_wdata[30:0];
        CFG_LIN_DAMP:    lin_damp_r    <= cfg_wdata[16:0];
        CFG_ANG_DAMP:    ang_damp_r    <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.load_out) begin
      out_r <= '{vel_x: vx_r, vel_y: vy_r, ang_vel: w_r,
                 pos_x: px_r, pos_y: py_r, rotation: ang_r};
    end
  end

  // issue stage: operand select and the shared multiplier
  always_comb begin
    case (cmd.uop.a_sel)
      A_FX:    a_val = in_r.force_x;
      A_FY:    a_val = in_r.force_y;
      A_TQ:    a_val = in_r.torque;
      A_IX:    a_val = in_r.impulse_x;
      A_IY:    a_val = in_r.impulse_y;
      A_CX:    a_val = in_r.contact_x;
      A_CY:    a_val = in_r.contact_y;
      A_VX:    a_val = vx_r;
      A_VY:    a_val = vy_r;
      A_W:     a_val = w_r;
      A_T0:    a_val = t0_r;
      A_T1:    a_val = t1_r;
      A_T2:    a_val = t2_r;
      default: a_val = '0;
    endcase
    case (cmd.uop.b_sel)
      B_IM:    b_val = {1'b0, inv_mass_r};
      B_II:    b_val = {1'b0, inv_inertia_r};
      B_FDT:   b_val = {1'b0, fixed_dt_r};
      B_LD:    b_val = {{(W-17){1'b0}}, lin_damp_r};
      B_AD:    b_val = {{(W-17){1'b0}}, ang_damp_r};
      B_DT:    b_val = {1'b0, in_r.dt};
      B_IX:    b_val = in_r.impulse_x;
      B_IY:    b_val = in_r.impulse_y;
      default: b_val = '0;
    endcase
    prod = a_val * b_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
    end else begin
      wb_vld_r <= cmd.issue;
    end
    if (cmd.issue) begin
      // dropping the low 16 bits of a two's complement product floors it
      prod_r   <= prod[2*W-1:16];
      wb_uop_r <= cmd.uop;
    end
  end

  // write-back stage: saturate, accumulate, saturate
  always_comb begin
    if ((&prod_r[2*W-17:W-1]) || !(|prod_r[2*W-17:W-1])) begin
      p_sat = prod_r[W-1:0];
    end else begin
      p_sat = prod_r[2*W-17] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    case (wb_uop_r.dst)
      D_VX:    dst_val = vx_r;
      D_VY:    dst_val = vy_r;
      D_W:     dst_val = w_r;
      D_PX:    dst_val = px_r;
      D_PY:    dst_val = py_r;
      D_ANG:   dst_val = ang_r;
      D_T0:    dst_val = t0_r;
      D_T1:    dst_val = t1_r;
      D_T2:    dst_val = t2_r;
      default: dst_val = '0;
    endcase
    case (wb_uop_r.add_sel)
      S_ZERO:  addend = '0;
      S_GX:    addend = grav_x_r;
      S_GY:    addend = grav_y_r;
      S_DST:   addend = dst_val;
      S_T0:    addend = t0_r;
      default: addend = '0;
    endcase
    if (wb_uop_r.sub) begin
      sum = {addend[W-1], addend} - {p_sat[W-1], p_sat};
    end else begin
      sum = {addend[W-1], addend} + {p_sat[W-1], p_sat};
    end
    if (sum[W] != sum[W-1]) begin
      res = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r  <= '0;
      vy_r  <= '0;
      w_r   <= '0;
      px_r  <= '0;
      py_r  <= '0;
      ang_r <= '0;
    end else if (wb_vld_r) begin
      case (wb_uop_r.dst)
        D_VX:  vx_r  <= res;
        D_VY:  vy_r  <= res;
        D_W:   w_r   <= res;
        D_PX:  px_r  <= res;
        D_PY:  py_r  <= res;
        D_ANG: ang_r <= res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wb_vld_r) begin
      case (wb_uop_r.dst)
        D_T0:    t0_r <= res;
        D_T1:    t1_r <= res;
        D_T2:    t2_r <= res;
        default: ;
      endcase
    end
  end

endmodule

/* design/rigid_body_2d_integrator_core.sv */
// channel   ports                               moves
// in        in_valid / in_ready / in_data       one request (in_req_t)
// out       out_valid / out_ready / out_data    body state after it (out_res_t)
// cfg       cfg_we / cfg_index / cfg_wdata      register write, no handshake
//
// A request is accepted, then issues its multiplies (integrate 9, impulse 5,
// advance 3) on the single shared 32x32 multiplier, one multiply per cycle,
// then the last write-back drains and the result register is loaded; a static
// body (integrate or advance) or an unused code issues no multiply.
// A waiting result does not block the next accept; the result register
// only delays the end of the next request. Reset is synchronous, clears the
// body state and sets the config registers to their defaults.
module rigid_body_2d_integrator_core
  import rbi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_res_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rbi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .cmd         (cmd)
  );

  rbi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

/* design/rbi_checker.sv */
module rbi_checker
  import rbi_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_res_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a request while one is in flight");

  // a fresh result only follows a busy cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind rigid_body_2d_integrator_core rbi_checker u_rbi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
